// ===== hw/rtl/iidl_pkg.sv =====
// Shared types and codes for the indexed insert/delete list.
// Used by the list controller; has no dependencies of its own.
`default_nettype none

package iidl_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_POP    = 3'd2,
        CMD_GET    = 3'd3,
        CMD_SET    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_BOUNDS = 2'd1,
        STS_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_FLUSH,
        ST_INS_PUT,
        ST_POP_HEAD,
        ST_POP_SHIFT,
        ST_POP_FLUSH,
        ST_GET_RD
    } t_state;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 7;

endpackage

`default_nettype wire

// ===== hw/rtl/indexed_insert_delete_list.sv =====
// Indexed insert/delete list held in one RAM with registered read data. Append, set, unknown
// commands and failures are answered from the accepting edge; get via ST_GET_RD, a pop of the
// last entry via ST_POP_HEAD, other pops via ST_POP_HEAD, ST_POP_SHIFT and ST_POP_FLUSH, an
// insert below the end via ST_INS_SHIFT, ST_INS_FLUSH and ST_INS_PUT; the RAM moves one entry
// per cycle. busy falls as the result is issued, so the next transfer may follow at once.
// Results cannot be stalled. Reset (synchronous, active low) empties the list, not the RAM.
`default_nettype none

module indexed_insert_delete_list #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [iidl_pkg::CMD_W-1:0]      i_command,
    input  wire logic [iidl_pkg::POS_W-1:0]      i_position,
    input  wire logic [iidl_pkg::WORD_W-1:0]     i_write_word,
    output logic                                 o_result_strobe,
    output logic [iidl_pkg::STATUS_W-1:0]        o_status,
    output logic [iidl_pkg::WORD_W-1:0]          o_read_word,
    output logic [iidl_pkg::COUNT_W-1:0]         o_count
);

    import iidl_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned LW = $clog2(DEPTH + 1);
    localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;

    t_state              r_state, n_state;
    logic [LW-1:0]       r_len, n_len;
    logic [AW-1:0]       r_rd, n_rd;
    logic [AW-1:0]       r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_word, n_word;
    logic                r_wr_v, n_wr_v;
    logic [AW-1:0]       r_wr_addr, n_wr_addr;
    logic [DATA_WIDTH-1:0] r_hold, n_hold;
    logic                r_strobe, n_strobe;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [WORD_W-1:0]   r_rword, n_rword;
    logic [COUNT_W-1:0]  r_count, n_count;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  accept;
    t_cmd                  cmd;
    logic [CW-1:0]         pos_w;
    logic [CW-1:0]         len_w;
    logic [63:0]           in_wide;
    logic [DATA_WIDTH-1:0] in_data;
    logic [63:0]           rd_wide;
    logic [63:0]           hold_wide;
    logic                  full;
    logic [AW-1:0]         last_idx;

    assign accept    = start && (r_state == ST_IDLE);
    assign cmd       = t_cmd'(i_command);
    assign pos_w     = CW'(i_position);
    assign len_w     = CW'(r_len);
    assign in_wide   = {32'd0, i_write_word};
    assign in_data   = in_wide[DATA_WIDTH-1:0];
    assign rd_wide   = 64'(ram_rdata);
    assign hold_wide = 64'(r_hold);
    assign full      = (r_len == LW'(DEPTH));
    assign last_idx  = AW'(r_len - LW'(1));

    iidl_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_INSERT: begin
                            if (pos_w < len_w && !full) begin
                                n_state = ST_INS_SHIFT;
                            end
                        end
                        CMD_POP: begin
                            if (pos_w < len_w) begin
                                n_state = ST_POP_HEAD;
                            end
                        end
                        CMD_GET: begin
                            if (pos_w < len_w) begin
                                n_state = ST_GET_RD;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_INS_SHIFT: begin
                if (r_rd == r_pos) begin
                    n_state = ST_INS_FLUSH;
                end
            end
            ST_INS_FLUSH: n_state = ST_INS_PUT;
            ST_INS_PUT:   n_state = ST_IDLE;
            ST_POP_HEAD: begin
                if (r_pos == last_idx) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_POP_SHIFT;
                end
            end
            ST_POP_SHIFT: begin
                if (r_rd == last_idx) begin
                    n_state = ST_POP_FLUSH;
                end
            end
            ST_POP_FLUSH: n_state = ST_IDLE;
            ST_GET_RD:    n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Datapath, RAM port control and result register.
    always_comb begin
        n_len     = r_len;
        n_rd      = r_rd;
        n_pos     = r_pos;
        n_word    = r_word;
        n_wr_v    = 1'b0;
        n_wr_addr = r_wr_addr;
        n_hold    = r_hold;
        n_strobe  = 1'b0;
        n_status  = STS_OK;
        n_rword   = '0;
        n_count   = r_count;
        ram_raddr = r_rd;
        // A pending move writes the word read in the previous cycle.
        ram_we    = r_wr_v;
        ram_waddr = r_wr_addr;
        ram_wdata = ram_rdata;

        case (r_state)
            ST_IDLE: begin
                ram_raddr = pos_w[AW-1:0];
                n_pos     = pos_w[AW-1:0];
                n_word    = in_data;
                if (accept) begin
                    n_count = COUNT_W'(r_len);
                    case (cmd)
                        CMD_INSERT, CMD_APPEND: begin
                            if (cmd == CMD_INSERT && pos_w > len_w) begin
                                n_strobe = 1'b1;
                                n_status = STS_BOUNDS;
                            end else if (full) begin
                                n_strobe = 1'b1;
                                n_status = STS_FULL;
                            end else if (cmd == CMD_APPEND || pos_w == len_w) begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_len);
                                ram_wdata = in_data;
                                n_len     = r_len + LW'(1);
                                n_strobe  = 1'b1;
                                n_count   = COUNT_W'(r_len + LW'(1));
                            end else begin
                                n_rd = last_idx;
                            end
                        end
                        CMD_POP, CMD_GET: begin
                            if (pos_w >= len_w) begin
                                n_strobe = 1'b1;
                                n_status = STS_BOUNDS;
                            end
                        end
                        CMD_SET: begin
                            n_strobe = 1'b1;
                            if (pos_w >= len_w) begin
                                n_status = STS_BOUNDS;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_w[AW-1:0];
                                ram_wdata = in_data;
                            end
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            ST_INS_SHIFT: begin
                // Walk down from the top; each word read moves up one place.
                n_wr_v    = 1'b1;
                n_wr_addr = r_rd + AW'(1);
                if (r_rd != r_pos) begin
                    n_rd = r_rd - AW'(1);
                end
            end
            ST_INS_FLUSH: begin
            end
            ST_INS_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_word;
                n_len     = r_len + LW'(1);
                n_strobe  = 1'b1;
                n_count   = COUNT_W'(r_len + LW'(1));
            end
            ST_POP_HEAD: begin
                n_hold = ram_rdata;
                n_rd   = r_pos + AW'(1);
                if (r_pos == last_idx) begin
                    n_len    = r_len - LW'(1);
                    n_strobe = 1'b1;
                    n_rword  = rd_wide[WORD_W-1:0];
                    n_count  = COUNT_W'(r_len - LW'(1));
                end
            end
            ST_POP_SHIFT: begin
                // Walk up from above the gap; each word read moves down one place.
                n_wr_v    = 1'b1;
                n_wr_addr = r_rd - AW'(1);
                if (r_rd != last_idx) begin
                    n_rd = r_rd + AW'(1);
                end
            end
            ST_POP_FLUSH: begin
                n_len    = r_len - LW'(1);
                n_strobe = 1'b1;
                n_rword  = hold_wide[WORD_W-1:0];
                n_count  = COUNT_W'(r_len - LW'(1));
            end
            ST_GET_RD: begin
                n_strobe = 1'b1;
                n_rword  = rd_wide[WORD_W-1:0];
                n_count  = COUNT_W'(r_len);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_len    <= '0;
            r_wr_v   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_wr_v   <= n_wr_v;
            r_strobe <= n_strobe;
        end
        r_rd      <= n_rd;
        r_pos     <= n_pos;
        r_word    <= n_word;
        r_wr_addr <= n_wr_addr;
        r_hold    <= n_hold;
        r_status  <= n_status;
        r_rword   <= n_rword;
        r_count   <= n_count;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_status        = r_status;
    assign o_read_word     = r_rword;
    assign o_count         = r_count;

endmodule

`default_nettype wire

// ===== hw/rtl/iidl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module iidl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== bench/indexed_insert_delete_list_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for indexed_insert_delete_list: drives list requests and compares
// every result against a behavioural list kept alongside. Depends on iidl_pkg and the RTL.

module indexed_insert_delete_list_test;

    import iidl_pkg::*;

    localparam int          DEPTH_N          = 64;
    localparam int          ITEM_TOTAL       = 1950;
    localparam int          CYCLE_LIMIT      = 1_000_000;
    localparam int          TAIL_CYCLES      = 80;
    localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
    } list_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   word;
        logic [COUNT_W-1:0]  count;
    } list_reply_t;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic [CMD_W-1:0]    i_command    = '0;
    logic [POS_W-1:0]    i_position   = '0;
    logic [WORD_W-1:0]   i_write_word = '0;
    logic                busy;
    logic                o_result_strobe;
    logic [STATUS_W-1:0] o_status;
    logic [WORD_W-1:0]   o_read_word;
    logic [COUNT_W-1:0]  o_count;

    list_req_t   request_backlog[$];
    list_reply_t expected_replies[$];
    logic [WORD_W-1:0] shadow_words[DEPTH_N];
    int          shadow_len     = 0;
    int          planned_len    = 0;
    bit          growing        = 1'b1;
    int          requests_total = 0;
    int          requests_sent  = 0;
    int          error_count    = 0;
    int          cycle_count    = 0;
    logic        req_taken      = 1'b0;

    indexed_insert_delete_list #(
        .DEPTH      (DEPTH_N),
        .DATA_WIDTH (WORD_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_position      (i_position),
        .i_write_word    (i_write_word),
        .o_result_strobe (o_result_strobe),
        .o_status        (o_status),
        .o_read_word     (o_read_word),
        .o_count         (o_count)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Applies one request to the shadow list and returns the reply it should produce.
    function automatic list_reply_t apply_list_request(list_req_t r);
        list_reply_t rep;
        int          p;
        rep.status = STS_OK;
        rep.word   = '0;
        p          = int'(r.pos);
        case (r.cmd)
            CMD_INSERT, CMD_APPEND: begin
                if (r.cmd == CMD_APPEND)
                    p = shadow_len;
                if (p > shadow_len) begin
                    rep.status = STS_BOUNDS;
                end else if (shadow_len >= DEPTH_N) begin
                    rep.status = STS_FULL;
                end else begin
                    for (int i = shadow_len; i > p; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[p] = r.word;
                    shadow_len++;
                end
            end
            CMD_POP: begin
                if (p >= shadow_len) begin
                    rep.status = STS_BOUNDS;
                end else begin
                    rep.word = shadow_words[p];
                    for (int i = p + 1; i < shadow_len; i++)
                        shadow_words[i-1] = shadow_words[i];
                    shadow_len--;
                end
            end
            CMD_GET: begin
                if (p >= shadow_len)
                    rep.status = STS_BOUNDS;
                else
                    rep.word = shadow_words[p];
            end
            CMD_SET: begin
                if (p >= shadow_len)
                    rep.status = STS_BOUNDS;
                else
                    shadow_words[p] = r.word;
            end
            default: ;
        endcase
        rep.count = COUNT_W'(shadow_len);
        return rep;
    endfunction

    // Queues a request and tracks the length it will leave, so that later positions
    // can be aimed at the valid range.
    function automatic void queue_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                          logic [WORD_W-1:0] word);
        list_req_t r;
        r.cmd  = cmd;
        r.pos  = pos;
        r.word = word;
        request_backlog.push_back(r);
        if (cmd == CMD_INSERT && int'(pos) <= planned_len && planned_len < DEPTH_N)
            planned_len++;
        else if (cmd == CMD_APPEND && planned_len < DEPTH_N)
            planned_len++;
        else if (cmd == CMD_POP && int'(pos) < planned_len)
            planned_len--;
    endfunction

    // The list swings between filling up and draining so that both the full and the
    // empty corners are visited many times. Returns 0 for an unused command code.
    function automatic bit queue_random_request();
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [WORD_W-1:0] word;
        if (growing && planned_len == DEPTH_N && $urandom_range(7) == 0)
            growing = 1'b0;
        if (!growing && planned_len == 0 && $urandom_range(3) == 0)
            growing = 1'b1;
        pick = $urandom_range(99);
        if (pick < 3)
            cmd = CMD_UNUSED_FIRST + 3'($urandom_range(2));
        else if (pick < (growing ? 38 : 13))
            cmd = CMD_INSERT;
        else if (pick < (growing ? 63 : 21))
            cmd = CMD_APPEND;
        else if (pick < (growing ? 73 : 71))
            cmd = CMD_POP;
        else if (pick < (growing ? 86 : 85))
            cmd = CMD_GET;
        else
            cmd = CMD_SET;
        if ($urandom_range(99) < 12 || (cmd != CMD_INSERT && planned_len == 0))
            pos = POS_W'($urandom_range(127));
        else if (cmd == CMD_INSERT)
            pos = POS_W'($urandom_range(planned_len));
        else
            pos = POS_W'($urandom_range(planned_len - 1));
        pick = $urandom_range(19);
        word = (pick == 0) ? '0 : (pick == 1) ? '1 : WORD_W'($urandom);
        queue_request(cmd, pos, word);
        return cmd < CMD_UNUSED_FIRST;
    endfunction

    // Driver: presents the next request once the previous one has been transferred.
    always @(negedge i_clk) begin
        list_req_t r;
        int        idle_pct;
        if (requests_sent < requests_total / 3)
            idle_pct = 6;
        else if (requests_sent < (2 * requests_total) / 3)
            idle_pct = 76;
        else
            idle_pct = 0;
        if (i_rst_n && (!start || req_taken)) begin
            if (request_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
                r             = request_backlog.pop_front();
                start        <= 1'b1;
                i_command    <= r.cmd;
                i_position   <= r.pos;
                i_write_word <= r.word;
                requests_sent++;
            end else begin
                // Junk on the payload while start is low must be ignored.
                start        <= 1'b0;
                i_command    <= CMD_W'($urandom);
                i_position   <= POS_W'($urandom);
                i_write_word <= WORD_W'($urandom);
            end
        end
    end

    // Monitor: predicts on each accepted request and checks each strobed result.
    always @(posedge i_clk) begin
        list_req_t   r;
        list_reply_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else if (i_rst_n) begin
            req_taken <= start && !busy;
            if (o_result_strobe) begin
                if (expected_replies.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    error_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_read_word !== want.word) begin
                        $error("read_word: expected %h, got %h", want.word, o_read_word);
                        error_count++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_count);
                        error_count++;
                    end
                end
            end
            if (start && !busy) begin
                r.cmd  = i_command;
                r.pos  = i_position;
                r.word = i_write_word;
                expected_replies.push_back(apply_list_request(r));
            end
        end else begin
            req_taken <= 1'b0;
        end
    end

    initial begin
        // Empty list: get, pop, set and an insert beyond the length are out of range.
        queue_request(CMD_GET,    '0, 32'h1234_5678);
        queue_request(CMD_POP,    '0, '0);
        queue_request(CMD_SET,    '0, '1);
        queue_request(CMD_INSERT, 7'd1, '1);
        queue_request(CMD_INSERT, '0, '1);
        queue_request(CMD_APPEND, '0, '0);
        // Insert at the current length behaves as an append.
        queue_request(CMD_INSERT, 7'd2, 32'hA5A5_5A5A);
        queue_request(CMD_INSERT, '0, 32'h0000_0001);
        queue_request(CMD_INSERT, '1, 32'hDEAD_BEEF);
        queue_request(CMD_GET,    '1, '0);
        queue_request(CMD_GET,    7'd3, '0);
        queue_request(CMD_GET,    7'd4, '0);
        queue_request(CMD_SET,    7'd1, '1);
        queue_request(CMD_SET,    7'd4, '0);
        // Append takes no notice of the position field.
        queue_request(CMD_APPEND, '1, 32'h8000_0000);
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
            queue_request(CMD_W'(c), POS_W'($urandom), WORD_W'($urandom));
        queue_request(CMD_GET,    '0, '0);
        queue_request(CMD_POP,    '0, '0);
        queue_request(CMD_POP,    7'd3, '0);
        queue_request(CMD_POP,    7'd3, '0);
        queue_request(CMD_POP,    7'd1, '0);

        while (request_backlog.size() < ITEM_TOTAL)
            void'(queue_random_request());
        requests_total = request_backlog.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_backlog.size() > 0 || start || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_replies.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== indexed_insert_delete_list.f =====
hw/rtl/iidl_pkg.sv
hw/rtl/iidl_ram.sv
hw/rtl/indexed_insert_delete_list.sv
bench/indexed_insert_delete_list_test.sv
